// File: rtl/gta_pkg.sv
// Shared constants for the GELU tanh-approximation activation pipeline.
package gta_pkg;

   // Default sample format: signed Q4.12.
   localparam int DATA_WIDTH_DEF = 16;
   localparam int FRAC_BITS_DEF  = 12;

   // Internal fraction bits of the datapath (Q.24).
   localparam int QF = 24;

   // Internal widths (signed unless noted), sized for the value ranges that occur.
   localparam int XC_W  = 28;  // clamped sample, |xc| <= 4.0
   localparam int X2_W  = 30;  // xc^2 <= 16.0
   localparam int X3_W  = 32;  // xc^3 <= 64.0
   localparam int S_W   = 29;  // polynomial, |s| < 8.0
   localparam int U_W   = 29;  // tanh argument, |u| < 8.0
   localparam int U2_W  = 31;  // u^2
   localparam int A_W   = 31;  // 27 + u^2 inside the tanh domain
   localparam int NUM_W = 32;  // rational numerator
   localparam int MAG_W = 31;  // numerator magnitude (unsigned)
   localparam int DEN_W = 31;  // rational denominator (unsigned)
   localparam int N_W   = 56;  // scaled dividend (unsigned)
   localparam int QB    = 26;  // quotient bits, one per divider stage
   localparam int REM_W = 31;  // partial remainder (unsigned)
   localparam int TP_W  = 28;  // 1 + tanh, in Q.24

   // 0.044715 and sqrt(2/pi), both in Q0.24.
   localparam logic signed [20:0] C_CUBIC   = 21'sd750193;
   localparam logic signed [24:0] C_SQRT2PI = 25'sd13386282;

endpackage

// File: rtl/gelu_tanh_activation.sv
// Streaming GELU activation (tanh approximation) as a fully pipelined datapath.
//
// gelu_tanh_activation computes GELU(x) = 0.5*x*(1 + tanh(u)) with
// u = sqrt(2/pi)*(x + 0.044715*x^3) on one signed fixed-point sample per request,
// where tanh(u) is replaced by the rational form u*(27 + u^2)/(27 + 9*u^2) and is
// forced to exactly +1 or -1 once |u| reaches 3. The sample carries FRAC_BITS
// fraction bits in DATA_WIDTH bits (Q4.12 by default); the result has the same
// format, is rounded to nearest and saturates at the ends of the range. The
// end-of-vector mark rides along with its sample unchanged. The block keeps no
// state between requests, so results depend only on their own request. It takes
// one request every clock cycle and delivers one result every cycle while the
// receiver does not stall. From request to result, seven stages evaluate the
// polynomial and the rational terms, one stage prepares the dividend, 26
// stages of a restoring divider produce one quotient bit each, and two stages
// form and scale x*(1 + tanh). The divider depth is what sets the latency.
// The output register is backed by one skid entry, so a stalled result never
// holds up the input by itself; the input is stalled only while the skid
// entry is occupied, and it frees again in the cycle after the receiver
// takes the waiting result.
module gelu_tanh_activation
   import gta_pkg::*;
#(
   parameter int DATA_WIDTH = DATA_WIDTH_DEF,
   parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   // Request channel.
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic signed [DATA_WIDTH-1:0] req_sample,
   input  logic                         req_last_in,
   // Result channel.
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic signed [DATA_WIDTH-1:0] rsp_activation,
   output logic                         rsp_last_out
);

   // Clamp width: wide enough for the sample and for +-4.0 in the sample format.
   localparam int XE = (DATA_WIDTH > FRAC_BITS + 4) ? DATA_WIDTH : FRAC_BITS + 4;
   // Clamped sample width before conversion to Q.24.
   localparam int XL = FRAC_BITS + 4;
   // Pipeline depth in register stages ahead of the output register.
   localparam int NSTG = QB + 10;
   // Final product width.
   localparam int PW = DATA_WIDTH + TP_W;

   localparam logic signed [XE-1:0]    LIM_P   = XE'(longint'(4) <<< FRAC_BITS);
   localparam logic signed [XE-1:0]    LIM_N   = -LIM_P;
   localparam logic signed [U_W-1:0]   THREE_Q = U_W'(3 * (1 << QF));
   localparam logic signed [A_W-1:0]   C27_Q   = A_W'(27 * (1 << QF));
   localparam logic signed [TP_W-1:0]  ONE_TP  = TP_W'(1 << QF);
   localparam logic signed [TP_W-1:0]  TWO_TP  = TP_W'(1 << (QF + 1));
   localparam logic signed [PW:0]      G_MAX   =
      (PW + 1)'((longint'(1) <<< (DATA_WIDTH - 1)) - 1);
   localparam logic signed [PW:0]      G_MIN   = -G_MAX - 1;

   // ------------------------------------------------------------------------
   // Flow control. The whole pipeline advances together unless the skid entry
   // holds a result, which happens only when the output register was stalled.
   // ------------------------------------------------------------------------
   logic                         pipe_en;
   logic [NSTG-1:0]              vld_ff;

   logic                         out_v_ff, out_v_in;
   logic signed [DATA_WIDTH-1:0] out_act_ff, out_act_in;
   logic                         out_last_ff, out_last_in;
   logic                         skid_v_ff, skid_v_in;
   logic signed [DATA_WIDTH-1:0] skid_act_ff, skid_act_in;
   logic                         skid_last_ff, skid_last_in;

   assign pipe_en   = !skid_v_ff;
   assign req_stall = skid_v_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (pipe_en) begin
         vld_ff <= {vld_ff[NSTG-2:0], req_valid};
      end
   end

   // ------------------------------------------------------------------------
   // Stage 1: clamp |x| to 4.0 and convert to Q.24. Beyond 4.0 the tanh term
   // is already saturated, so the clamp does not change the result.
   // ------------------------------------------------------------------------
   logic signed [XE-1:0]         x_ext, xl;
   logic signed [XL-1:0]         xl_n;
   logic signed [XC_W-1:0]       xc_in;
   logic signed [DATA_WIDTH-1:0] p1_x_ff;
   logic                         p1_last_ff;
   logic signed [XC_W-1:0]       p1_xc_ff;

   assign x_ext = XE'(req_sample);

   always_comb begin
      if (x_ext > LIM_P) begin
         xl = LIM_P;
      end else if (x_ext < LIM_N) begin
         xl = LIM_N;
      end else begin
         xl = x_ext;
      end
   end

   assign xl_n = xl[XL-1:0];

   if (FRAC_BITS <= QF) begin : g_xc_up
      assign xc_in = XC_W'(xl_n) <<< (QF - FRAC_BITS);
   end else begin : g_xc_dn
      localparam int SH = FRAC_BITS - QF;
      logic signed [XL:0] xr;
      assign xr    = (XL + 1)'(xl_n) + ((XL + 1)'(1) <<< (SH - 1));
      assign xc_in = XC_W'(xr >>> SH);
   end

   // ------------------------------------------------------------------------
   // Stages 2 to 7: polynomial, tanh argument and the rational terms.
   // Every product is rounded back to Q.24 (ties toward plus infinity).
   // ------------------------------------------------------------------------
   logic signed [2*XC_W-1:0]      prod_x2;
   logic signed [2*XC_W-1:0]      rnd_x2;
   logic signed [X2_W+XC_W-1:0]   prod_x3;
   logic signed [X2_W+XC_W-1:0]   rnd_x3;
   logic signed [X3_W+20:0]       prod_c;
   logic signed [X3_W+20:0]       rnd_c;
   logic signed [S_W+24:0]        prod_u;
   logic signed [S_W+24:0]        rnd_u;
   logic signed [2*U_W-1:0]       prod_uu;
   logic signed [2*U_W-1:0]       rnd_uu;
   logic signed [A_W-1:0]         a_val;
   logic signed [U_W+A_W-1:0]     prod_num;
   logic signed [U_W+A_W-1:0]     rnd_num;

   logic signed [X2_W-1:0]        x2_in;
   logic signed [X3_W-1:0]        x3_in;
   logic signed [S_W-1:0]         s_in;
   logic signed [U_W-1:0]         u_in;
   logic signed [U2_W-1:0]        u2_in;
   logic                          cpos_in, cneg_in;
   logic signed [NUM_W-1:0]       num_in;
   logic [DEN_W-1:0]              den_in;

   logic signed [DATA_WIDTH-1:0]  p2_x_ff, p3_x_ff, p4_x_ff, p5_x_ff, p6_x_ff, p7_x_ff;
   logic                          p2_last_ff, p3_last_ff, p4_last_ff;
   logic                          p5_last_ff, p6_last_ff, p7_last_ff;
   logic signed [XC_W-1:0]        p2_xc_ff, p3_xc_ff;
   logic signed [X2_W-1:0]        p2_x2_ff;
   logic signed [X3_W-1:0]        p3_x3_ff;
   logic signed [S_W-1:0]         p4_s_ff;
   logic signed [U_W-1:0]         p5_u_ff, p6_u_ff;
   logic signed [U2_W-1:0]        p6_u2_ff;
   logic                          p6_cpos_ff, p6_cneg_ff, p7_cpos_ff, p7_cneg_ff;
   logic signed [NUM_W-1:0]       p7_num_ff;
   logic [DEN_W-1:0]              p7_den_ff;

   assign prod_x2 = p1_xc_ff * p1_xc_ff;
   assign rnd_x2  = (prod_x2 + ((2*XC_W)'(1) <<< (QF - 1))) >>> QF;
   assign x2_in   = rnd_x2[X2_W-1:0];

   assign prod_x3 = p2_x2_ff * p2_xc_ff;
   assign rnd_x3  = (prod_x3 + ((X2_W+XC_W)'(1) <<< (QF - 1))) >>> QF;
   assign x3_in   = rnd_x3[X3_W-1:0];

   assign prod_c  = C_CUBIC * p3_x3_ff;
   assign rnd_c   = (prod_c + ((X3_W+21)'(1) <<< (QF - 1))) >>> QF;
   assign s_in    = S_W'(p3_xc_ff) + S_W'(rnd_c);

   assign prod_u  = C_SQRT2PI * p4_s_ff;
   assign rnd_u   = (prod_u + ((S_W+25)'(1) <<< (QF - 1))) >>> QF;
   assign u_in    = rnd_u[U_W-1:0];

   // The rational form is only evaluated meaningfully inside |u| < 3; outside,
   // the saturation flags override whatever the later stages compute.
   assign prod_uu = p5_u_ff * p5_u_ff;
   assign rnd_uu  = (prod_uu + ((2*U_W)'(1) <<< (QF - 1))) >>> QF;
   assign u2_in   = rnd_uu[U2_W-1:0];
   assign cpos_in = (p5_u_ff >= THREE_Q);
   assign cneg_in = (p5_u_ff <= -THREE_Q);

   assign a_val    = C27_Q + p6_u2_ff;
   assign prod_num = p6_u_ff * a_val;
   assign rnd_num  = (prod_num + ((U_W+A_W)'(1) <<< (QF - 1))) >>> QF;
   assign num_in   = rnd_num[NUM_W-1:0];
   assign den_in   = DEN_W'(C27_Q) + DEN_W'({p6_u2_ff, 3'b000}) + DEN_W'(p6_u2_ff);

   // ------------------------------------------------------------------------
   // Stage 8 (divider stage 0): dividend = |num|*2^24 + den/2, which turns the
   // truncating division into rounding to nearest with ties away from zero.
   // ------------------------------------------------------------------------
   logic                 neg_in;
   logic [NUM_W-1:0]     mag_full;
   logic [N_W-1:0]       nfull;
   logic [REM_W-1:0]     rem0_in;

   assign neg_in   = p7_num_ff[NUM_W-1];
   assign mag_full = neg_in ? NUM_W'(-p7_num_ff) : NUM_W'(p7_num_ff);
   assign nfull    = (N_W'(mag_full[MAG_W-1:0]) << QF) + N_W'(p7_den_ff >> 1);
   assign rem0_in  = REM_W'(nfull[N_W-1:QB]);

   // ------------------------------------------------------------------------
   // Divider stages 1 to QB: restoring division, one quotient bit per stage.
   // ------------------------------------------------------------------------
   logic [REM_W-1:0]             d_rem_ff  [QB+1];
   logic [QB-1:0]                d_nlo_ff  [QB+1];
   logic [QB-1:0]                d_q_ff    [QB+1];
   logic [DEN_W-1:0]             d_den_ff  [QB+1];
   logic signed [DATA_WIDTH-1:0] d_x_ff    [QB+1];
   logic [QB:0]                  d_last_ff, d_neg_ff, d_cpos_ff, d_cneg_ff;

   logic [REM_W:0]               div_trial [1:QB];
   logic [QB:1]                  div_ge;
   logic [REM_W-1:0]             div_rem_in [1:QB];

   always_comb begin
      for (int k = 1; k <= QB; k++) begin
         div_trial[k]  = {d_rem_ff[k-1], d_nlo_ff[k-1][QB-1]};
         div_ge[k]     = (div_trial[k] >= {1'b0, d_den_ff[k-1]});
         div_rem_in[k] = div_ge[k] ? REM_W'(div_trial[k] - {1'b0, d_den_ff[k-1]})
                                   : REM_W'(div_trial[k]);
      end
   end

   // ------------------------------------------------------------------------
   // Stage 9: signed tanh and 1 + tanh, with saturation at |u| >= 3.
   // Stage 10: x*(1 + tanh).
   // ------------------------------------------------------------------------
   logic signed [TP_W-1:0]       t_mag, t_val, tp_in;
   logic signed [DATA_WIDTH-1:0] p9_x_ff;
   logic                         p9_last_ff, p10_last_ff;
   logic signed [TP_W-1:0]       p9_tp_ff;
   logic signed [PW-1:0]         prod_g_in, p10_prod_ff;

   assign t_mag = TP_W'(d_q_ff[QB]);
   assign t_val = d_neg_ff[QB] ? -t_mag : t_mag;

   always_comb begin
      if (d_cpos_ff[QB]) begin
         tp_in = TWO_TP;
      end else if (d_cneg_ff[QB]) begin
         tp_in = '0;
      end else begin
         tp_in = ONE_TP + t_val;
      end
   end

   assign prod_g_in = p9_x_ff * p9_tp_ff;

   // Payload registers: no reset, they only move with the pipeline.
   always_ff @(posedge clock) begin
      if (pipe_en) begin
         p1_x_ff    <= req_sample;
         p1_last_ff <= req_last_in;
         p1_xc_ff   <= xc_in;

         p2_x_ff    <= p1_x_ff;
         p2_last_ff <= p1_last_ff;
         p2_xc_ff   <= p1_xc_ff;
         p2_x2_ff   <= x2_in;

         p3_x_ff    <= p2_x_ff;
         p3_last_ff <= p2_last_ff;
         p3_xc_ff   <= p2_xc_ff;
         p3_x3_ff   <= x3_in;

         p4_x_ff    <= p3_x_ff;
         p4_last_ff <= p3_last_ff;
         p4_s_ff    <= s_in;

         p5_x_ff    <= p4_x_ff;
         p5_last_ff <= p4_last_ff;
         p5_u_ff    <= u_in;

         p6_x_ff    <= p5_x_ff;
         p6_last_ff <= p5_last_ff;
         p6_u_ff    <= p5_u_ff;
         p6_u2_ff   <= u2_in;
         p6_cpos_ff <= cpos_in;
         p6_cneg_ff <= cneg_in;

         p7_x_ff    <= p6_x_ff;
         p7_last_ff <= p6_last_ff;
         p7_num_ff  <= num_in;
         p7_den_ff  <= den_in;
         p7_cpos_ff <= p6_cpos_ff;
         p7_cneg_ff <= p6_cneg_ff;

         d_rem_ff[0] <= rem0_in;
         d_nlo_ff[0] <= nfull[QB-1:0];
         d_q_ff[0]   <= '0;
         d_den_ff[0] <= p7_den_ff;
         d_x_ff[0]   <= p7_x_ff;
         d_last_ff   <= {d_last_ff[QB-1:0], p7_last_ff};
         d_neg_ff    <= {d_neg_ff[QB-1:0], neg_in};
         d_cpos_ff   <= {d_cpos_ff[QB-1:0], p7_cpos_ff};
         d_cneg_ff   <= {d_cneg_ff[QB-1:0], p7_cneg_ff};
         for (int k = 1; k <= QB; k++) begin
            d_rem_ff[k] <= div_rem_in[k];
            d_nlo_ff[k] <= {d_nlo_ff[k-1][QB-2:0], 1'b0};
            d_q_ff[k]   <= {d_q_ff[k-1][QB-2:0], div_ge[k]};
            d_den_ff[k] <= d_den_ff[k-1];
            d_x_ff[k]   <= d_x_ff[k-1];
         end

         p9_x_ff     <= d_x_ff[QB];
         p9_last_ff  <= d_last_ff[QB];
         p9_tp_ff    <= tp_in;

         p10_last_ff <= p9_last_ff;
         p10_prod_ff <= prod_g_in;
      end
   end

   // ------------------------------------------------------------------------
   // Output: divide by two and scale back to the sample format, round, then
   // saturate. The result goes to the output register, or to the skid entry
   // when the output register is occupied and stalled.
   // ------------------------------------------------------------------------
   logic signed [PW:0]           g_full;
   logic signed [DATA_WIDTH-1:0] act_new;
   logic                         new_v, out_take;

   assign g_full = ((PW + 1)'(p10_prod_ff) + ((PW + 1)'(1) <<< QF)) >>> (QF + 1);

   always_comb begin
      if (g_full > G_MAX) begin
         act_new = DATA_WIDTH'(G_MAX);
      end else if (g_full < G_MIN) begin
         act_new = DATA_WIDTH'(G_MIN);
      end else begin
         act_new = DATA_WIDTH'(g_full);
      end
   end

   assign new_v    = pipe_en && vld_ff[NSTG-1];
   assign out_take = out_v_ff && !rsp_stall;

   always_comb begin
      out_v_in     = out_v_ff;
      out_act_in   = out_act_ff;
      out_last_in  = out_last_ff;
      skid_v_in    = skid_v_ff;
      skid_act_in  = skid_act_ff;
      skid_last_in = skid_last_ff;
      if (skid_v_ff) begin
         // The pipeline is frozen; drain the skid entry once the output moves.
         if (out_take) begin
            out_act_in  = skid_act_ff;
            out_last_in = skid_last_ff;
            skid_v_in   = 1'b0;
         end
      end else if (new_v) begin
         if (!out_v_ff || out_take) begin
            out_v_in    = 1'b1;
            out_act_in  = act_new;
            out_last_in = p10_last_ff;
         end else begin
            skid_v_in    = 1'b1;
            skid_act_in  = act_new;
            skid_last_in = p10_last_ff;
         end
      end else if (out_take) begin
         out_v_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff  <= 1'b0;
         skid_v_ff <= 1'b0;
      end else begin
         out_v_ff  <= out_v_in;
         skid_v_ff <= skid_v_in;
      end
   end

   always_ff @(posedge clock) begin
      out_act_ff   <= out_act_in;
      out_last_ff  <= out_last_in;
      skid_act_ff  <= skid_act_in;
      skid_last_ff <= skid_last_in;
   end

   assign rsp_valid      = out_v_ff;
   assign rsp_activation = out_act_ff;
   assign rsp_last_out   = out_last_ff;

endmodule

// File: rtl/gta_checker.sv
// Port-level assertions for the GELU activation pipeline, bound to its top level.
module gta_checker
   import gta_pkg::*;
#(
   parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_stall,
   input logic                  rsp_valid,
   input logic                  rsp_stall,
   input logic [DATA_WIDTH-1:0] rsp_activation,
   input logic                  rsp_last_out
);

   // A stalled result stays in place.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_activation)
                                 && $stable(rsp_last_out))
      else $error("stalled result changed or vanished");

   // The input only stalls while a result is waiting behind the output.
   a_stall_has_rsp: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid)
      else $error("request stalled with no result pending");

   // The input stall starts only after the output was stalled.
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      $rose(req_stall) |-> $past(rsp_valid && rsp_stall))
      else $error("request stall without output backpressure");

   // Once the waiting result is taken, requests flow again in the next cycle.
   a_stall_release: assert property (@(posedge clock) disable iff (reset)
      req_stall && !rsp_stall |=> !req_stall)
      else $error("request stall held after the result was taken");

endmodule

bind gelu_tanh_activation gta_checker #(.DATA_WIDTH(DATA_WIDTH)) u_gta_checker (.*);

// File: sim/tb.sv
// Self-checking testbench for the GELU tanh-approximation activation pipeline.
`timescale 1ns / 100ps

module tb
   import gta_pkg::*;
();

   // The run gives up if it has not finished by this many cycles.
   localparam int unsigned LIMIT_CYCLES = 200000;
   // Cycles to wait after the last expected result, sized from the pipeline depth
   // plus the skid entry, with margin.
   localparam int unsigned TAIL_CYCLES = 64;
   localparam int unsigned RANDOM_TARGET = 1050;
   localparam int unsigned PRINT_CAP = 30;

   typedef logic signed [DATA_WIDTH_DEF-1:0] sample_type;

   // One pending request. With drain_first set, the sender holds it back until
   // every result that is already owed has come out of the block.
   typedef struct {
      sample_type sample;
      logic       last;
      logic       drain_first;
   } sample_item_type;

   // One owed result, in the order its request was accepted.
   typedef struct {
      sample_type activation;
      logic       last;
   } gelu_result_type;

   // Requests that exercise the ends of the range, the clamp at |x| = 4.0 and
   // both sides of the point where the tanh argument reaches 3, for either sign.
   localparam int DIRECTED[23] = '{
      -32768, 32767, 0, 1, -1,
      16384, -16384, 16385, -16385, 16383, -16383,
      11423, 11424, 11425, 11426, 11427, 11428,
      -11423, -11424, -11425, -11426, -11427, -11428
   };

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   sample_type req_sample = '0;
   logic       req_last_in = 1'b0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   sample_type rsp_activation;
   logic       rsp_last_out;

   sample_item_type sample_queue[$];
   gelu_result_type activation_due[$];
   sample_item_type next_item;

   int unsigned accepted_cnt = 0;
   int unsigned mismatch_cnt = 0;
   int unsigned cycle_cnt = 0;
   int unsigned tx_idle_pct;
   int unsigned rx_stall_pct;

   gelu_tanh_activation DUT (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_sample     (req_sample),
      .req_last_in    (req_last_in),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_activation (rsp_activation),
      .rsp_last_out   (rsp_last_out)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Idle pressure moves through three phases as requests are accepted: first the
   // sender pauses rarely while the receiver stalls often, then the other way
   // round, and at the end neither side holds anything back.
   assign tx_idle_pct  = (accepted_cnt < 360) ? 6 : (accepted_cnt < 720) ? 59 : 0;
   assign rx_stall_pct = (accepted_cnt < 360) ? 59 : (accepted_cnt < 720) ? 6 : 0;

   // Signed shift right with rounding to nearest, ties toward plus infinity.
   // An arithmetic shift floors, so adding half first gives exactly that.
   function automatic longint round_shift(longint v, int sh);
      return (v + (longint'(1) << (sh - 1))) >>> sh;
   endfunction

   // GELU of one sample in the block's fixed-point arithmetic. All internal
   // values carry QF fraction bits; the sample is clamped to |x| <= 4.0 before
   // the polynomial, since beyond that the tanh term is saturated anyway.
   function automatic sample_type gelu_tanh_q(sample_type x_in);
      longint one_q, lim, x, xl, xc, x2, x3, s, u, u2, num, den, mag, q, t, g;
      longint maxv, minv;
      one_q = longint'(1) << QF;
      lim   = longint'(4) << FRAC_BITS_DEF;
      maxv  = (longint'(1) << (DATA_WIDTH_DEF - 1)) - 1;
      minv  = -(longint'(1) << (DATA_WIDTH_DEF - 1));
      x     = x_in;
      xl    = (x > lim) ? lim : (x < -lim) ? -lim : x;
      xc    = xl * (longint'(1) << (QF - FRAC_BITS_DEF));
      x2    = round_shift(xc * xc, QF);
      x3    = round_shift(x2 * xc, QF);
      s     = xc + round_shift(longint'(C_CUBIC) * x3, QF);
      u     = round_shift(longint'(C_SQRT2PI) * s, QF);
      // Outside |u| < 3 the rational form is not used and tanh is exactly +-1.
      if (u >= 3 * one_q) begin
         t = one_q;
      end else if (u <= -3 * one_q) begin
         t = -one_q;
      end else begin
         u2  = round_shift(u * u, QF);
         num = round_shift(u * (27 * one_q + u2), QF);
         den = 27 * one_q + 9 * u2;
         // The quotient is formed on the magnitude, so ties round away from zero.
         mag = (num < 0) ? -num : num;
         q   = ((mag << QF) + (den >>> 1)) / den;
         t   = (num < 0) ? -q : q;
      end
      g = round_shift(x * (one_q + t), QF + 1);
      if (g > maxv) begin
         g = maxv;
      end
      if (g < minv) begin
         g = minv;
      end
      return sample_type'(g);
   endfunction

   // Prints one line per mismatch up to a cap, and counts every one of them.
   task automatic report_mismatch(string what);
      mismatch_cnt++;
      if (mismatch_cnt <= PRINT_CAP) begin
         $display("tb: MISMATCH at cycle %0d: %s", cycle_cnt, what);
      end
   endtask

   // Picks a random sample. The mix weighs the range inside |x| <= 4.0 and the
   // neighborhood of the tanh clamp, where the rational form does the work.
   function automatic sample_type random_sample();
      int mag;
      unique case ($urandom_range(3))
         0: return sample_type'($urandom);
         1: return sample_type'(int'($urandom_range(32768)) - 16384);
         2: begin
            mag = $urandom_range(11000, 11900);
            return sample_type'($urandom_range(1) ? mag : -mag);
         end
         default: return sample_type'(int'($urandom_range(1024)) - 512);
      endcase
   endfunction

   // Request driver. When a request is accepted, its expected result is queued
   // at once. A new request is offered only once the channel is free, and a
   // request that is stalled keeps its payload unchanged.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            activation_due.push_back(gelu_result_type'{activation: gelu_tanh_q(req_sample),
                                                       last: req_last_in});
            accepted_cnt <= accepted_cnt + 1;
         end
         if (!req_valid || !req_stall) begin
            if (sample_queue.size() != 0 &&
                !(sample_queue[0].drain_first && activation_due.size() != 0) &&
                $urandom_range(99) >= tx_idle_pct) begin
               next_item = sample_queue.pop_front();
               req_valid   <= 1'b1;
               req_sample  <= next_item.sample;
               req_last_in <= next_item.last;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Result monitor. Every accepted result is checked field by field against the
   // oldest owed result; the receiver stall is redrawn each cycle.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (activation_due.size() == 0) begin
               report_mismatch($sformatf("result %0d with no request owed",
                                         rsp_activation));
            end else begin
               if (rsp_activation !== activation_due[0].activation) begin
                  report_mismatch($sformatf("activation %0d, expected %0d",
                                            rsp_activation, activation_due[0].activation));
               end
               if (rsp_last_out !== activation_due[0].last) begin
                  report_mismatch($sformatf("last_out %b, expected %b",
                                            rsp_last_out, activation_due[0].last));
               end
               void'(activation_due.pop_front());
            end
         end
         rsp_stall <= ($urandom_range(99) < rx_stall_pct);
      end
   end

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycle_cnt <= cycle_cnt + 1;
      if (cycle_cnt == LIMIT_CYCLES) begin
         $display("tb: errors");
         $finish;
      end
   end

   // Stimulus and end of run.
   initial begin
      int unsigned     total;
      int unsigned     len;
      logic            broken;
      sample_item_type item;

      // Directed requests first, with the end mark taking both values.
      foreach (DIRECTED[i]) begin
         item.sample      = sample_type'(DIRECTED[i]);
         item.last        = (i % 4 == 3) || (i == $size(DIRECTED) - 1);
         item.drain_first = 1'b0;
         sample_queue.push_back(item);
      end

      // Random vectors of random length, each closed by its end mark. About one
      // vector in eight is broken and carries random end marks instead. The first
      // random request and one in the middle wait for the pipeline to drain.
      total = 0;
      while (total < RANDOM_TARGET) begin
         len    = $urandom_range(1, 16);
         broken = ($urandom_range(7) == 0);
         for (int k = 0; k < len; k++) begin
            item.sample      = random_sample();
            item.last        = broken ? 1'($urandom_range(1)) : (k == len - 1);
            item.drain_first = (total == 0) || (total == RANDOM_TARGET / 2);
            sample_queue.push_back(item);
            total++;
         end
      end

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Wait until every request has been accepted, then until every owed result
      // has arrived, then a while longer for anything the block still sends.
      while (sample_queue.size() != 0 || req_valid) begin
         @(posedge clock);
      end
      while (activation_due.size() != 0) begin
         @(posedge clock);
      end
      repeat (TAIL_CYCLES) @(posedge clock);

      if (activation_due.size() != 0) begin
         report_mismatch($sformatf("%0d results never arrived", activation_due.size()));
      end
      if (mismatch_cnt == 0) begin
         $display("tb: clean");
      end else begin
         $display("tb: errors");
      end
      $finish;
   end

endmodule
